@@ rtl/flac_pkg.sv @@
package flac_pkg;

	// Width of the item fields on the ports
	localparam int FIELD_W = 32;

	localparam int ENTRIES_DEFAULT    = 64;
	localparam int ENTRIES_MAX        = 8192;
	localparam int BLOCK_BITS_DEFAULT = 32;

	localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

	// Passed from each cell to the next one down the recency stack
	typedef struct packed {
		logic valid;  // cell holds a block
		logic found;  // this cell or one nearer the top matched the key
	} link_t;

endpackage

@@ rtl/flac_req_if.sv @@
interface flac_req_if;
	logic                         valid;
	logic                         ready;
	logic [flac_pkg::FIELD_W-1:0] block_number;

	modport source (output valid, output block_number, input ready);
	modport sink   (input valid, input block_number, output ready);
endinterface

@@ rtl/flac_rsp_if.sv @@
interface flac_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic                         evicted_valid;
	logic [flac_pkg::FIELD_W-1:0] evicted_block;
	logic [flac_pkg::FIELD_W-1:0] hit_total;
	logic [flac_pkg::FIELD_W-1:0] access_total;

	modport source (output valid, output hit, output evicted_valid, output evicted_block,
		output hit_total, output access_total, input ready);
	modport sink   (input valid, input hit, input evicted_valid, input evicted_block,
		input hit_total, input access_total, output ready);
endinterface

@@ rtl/fully_assoc_lru_cache_tracker.sv @@
// Fully associative LRU tracker over ENTRIES cells kept as a recency stack
// (cell 0 most recent). Each block_number item gives one result item: hit,
// evicted_valid/evicted_block (the least recently used block, pushed out by
// a miss on a full store, zero otherwise) and saturating hit and access
// totals that include the item itself. Only the low BLOCK_BITS bits of the
// block number are compared and stored. The tracker sustains one item per
// clock while results are taken; an accepted item is held in the key
// register, looked up combinationally, and its result registered in the
// result register. In the lookup every cell compares its tag with the key
// in parallel and the match ripples down the cell chain to decide which
// cells shift. A held result stalls the lookup stage, and with it the
// input. Reset clears all valid marks at once; no clearing pass follows it.
module fully_assoc_lru_cache_tracker #(
	parameter int ENTRIES    = flac_pkg::ENTRIES_DEFAULT,
	parameter int BLOCK_BITS = flac_pkg::BLOCK_BITS_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	flac_req_if.sink   req,
	flac_rsp_if.source rsp
);

	localparam int FW = flac_pkg::FIELD_W;

	logic                  busy_s1;
	logic [BLOCK_BITS-1:0] key_s1;
	logic [BLOCK_BITS-1:0] key_in;
	logic                  advance;

	flac_pkg::link_t       link [ENTRIES+1];
	logic [BLOCK_BITS-1:0] tag_chain [ENTRIES+1];
	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES-1:0]    match_vec;

	logic                  hit;
	logic                  evict;
	logic [FW-1:0]         victim;
	logic [FW-1:0]         hit_next;
	logic [FW-1:0]         access_next;

	logic                  rsp_valid_q;
	logic                  hit_q;
	logic                  evicted_valid_q;
	logic [FW-1:0]         evicted_block_q;
	logic [FW-1:0]         hit_total_q;
	logic [FW-1:0]         access_total_q;

	// Fit the port field to the stored tag width
	if (BLOCK_BITS > FW) begin : g_key_wide
		assign key_in = {{(BLOCK_BITS-FW){1'b0}}, req.block_number};
		assign victim = tag_chain[ENTRIES][FW-1:0];
	end else if (BLOCK_BITS == FW) begin : g_key_same
		assign key_in = req.block_number;
		assign victim = tag_chain[ENTRIES];
	end else begin : g_key_narrow
		assign key_in = req.block_number[BLOCK_BITS-1:0];
		assign victim = {{(FW-BLOCK_BITS){1'b0}}, tag_chain[ENTRIES]};
	end

	assign advance   = busy_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req.ready) begin
			busy_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_s1 <= key_in;
		end
	end

	// The top of the stack is fed with the key itself, always valid
	assign link[0].valid = 1'b1;
	assign link[0].found = 1'b0;
	assign tag_chain[0]  = key_s1;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		flac_cell #(
			.BLOCK_BITS(BLOCK_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (advance),
			.key      (key_s1),
			.prev_tag (tag_chain[i]),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.tag      (tag_chain[i+1])
		);
		assign valid_vec[i] = link[i+1].valid;
		assign match_vec[i] = link[i+1].found & ~link[i].found;
	end

	assign hit   = link[ENTRIES].found;
	assign evict = !hit && link[ENTRIES].valid;

	flac_sat_cnt u_hit_cnt (
		.clk        (clk),
		.arst_n     (arst_n),
		.inc        (advance && hit),
		.count_next (hit_next)
	);

	flac_sat_cnt u_access_cnt (
		.clk        (clk),
		.arst_n     (arst_n),
		.inc        (advance),
		.count_next (access_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q           <= hit;
			evicted_valid_q <= evict;
			evicted_block_q <= evict ? victim : '0;
			hit_total_q     <= hit_next;
			access_total_q  <= access_next;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_block = evicted_block_q;
	assign rsp.hit_total     = hit_total_q;
	assign rsp.access_total  = access_total_q;

	// Valid cells always form an unbroken run from the top
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec + 1'b1))
		else $error("valid cells not contiguous from the top");

	// A block is held in at most one cell
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> $onehot0(match_vec))
		else $error("key matched more than one cell");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(hit_q && evicted_valid_q))
		else $error("hit reported together with an eviction");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !evicted_valid_q) |-> (evicted_block_q == '0))
		else $error("evicted block not zero without an eviction");

	a_totals_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (hit_total_q <= access_total_q))
		else $error("hit total exceeds access total");

	// Only a full store can evict, and it stays full afterwards
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && evict) |=> valid_vec[ENTRIES-1])
		else $error("eviction left the store short of full");

endmodule

@@ rtl/flac_cell.sv @@
module flac_cell #(
	parameter int BLOCK_BITS = flac_pkg::BLOCK_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [BLOCK_BITS-1:0] key,
	input  logic [BLOCK_BITS-1:0] prev_tag,
	input  flac_pkg::link_t       link_in,
	output flac_pkg::link_t       link_out,
	output logic [BLOCK_BITS-1:0] tag
);

	logic                  valid_q;
	logic [BLOCK_BITS-1:0] tag_q;
	logic                  match;
	logic                  shift;

	assign match = valid_q && (tag_q == key);

	// Cells above the hit, the hit cell itself, and every cell on a miss take
	// their upper neighbour's contents; cells below a hit hold.
	assign shift = step && !link_in.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= prev_tag;
		end
	end

	assign link_out.valid = valid_q;
	assign link_out.found = link_in.found | match;
	assign tag            = tag_q;

endmodule

@@ rtl/flac_sat_cnt.sv @@
module flac_sat_cnt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         inc,
	output logic [flac_pkg::FIELD_W-1:0] count_next
);

	logic [flac_pkg::FIELD_W-1:0] count_q;

	// Stick at the top value
	always_comb begin
		count_next = count_q;
		if (inc && (count_q != flac_pkg::COUNT_MAX)) begin
			count_next = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

endmodule
